// File: hw/rtl/scan_reply_decoder_top_assert.svh
// Assertion macros for the scan reply decoder.
`ifndef SCAN_REPLY_DECODER_TOP_ASSERT_SVH
`define SCAN_REPLY_DECODER_TOP_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/srd_pkg.sv
// Types and constants shared by the scan reply decoder.
`timescale 1ns / 1ps
package srd_pkg;

  typedef enum logic [3:0] {
    PH_HDR_A = 4'd0,
    PH_HDR_B = 4'd1,
    PH_ECHO  = 4'd2,
    PH_ST0   = 4'd3,
    PH_ST1   = 4'd4,
    PH_ST2   = 4'd5,
    PH_ST3   = 4'd6,
    PH_STAMP = 4'd7,
    PH_DATA  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    FAULT_OK     = 2'd0,
    FAULT_HEADER = 2'd1,
    FAULT_STATUS = 2'd2
  } fault_e;

  localparam logic [7:0] LfChar    = 8'h0a;
  localparam logic [7:0] CharM     = 8'h4d;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] DigitBias = 8'h30;

endpackage

// File: hw/rtl/scan_reply_decoder_top.sv
// Scan reply decoder: byte-wide MD reply parser and three-character distance decoder.
// A result appears on the output register in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output register is empty or being drained; a
// result waiting in the output register stalls every byte until it is taken.
// Reset (rst_ni low, asynchronous): parser waits for a header, all counters cleared,
// output register empty.
`timescale 1ns / 1ps
`include "scan_reply_decoder_top_assert.svh"
module scan_reply_decoder_top
  import srd_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] distance_o,
  output logic [9:0]  point_number_o,
  output logic        scan_last_o,
  output logic [1:0]  fault_o
);

  localparam int PointCap = (MAX_POINTS > 1024) ? 1024 : ((MAX_POINTS < 1) ? 1 : MAX_POINTS);
  localparam logic [9:0] IdxLimit = 10'(PointCap - 1);

  phase_e      phase_q, phase_d;
  logic [7:0]  dly_char_q, dly_char_d;
  logic        dly_valid_q, dly_valid_d;
  logic [11:0] digit_sum_q, digit_sum_d;
  logic [1:0]  digit_cnt_q, digit_cnt_d;
  logic        lf_run_q, lf_run_d;
  logic [17:0] held_dist_q, held_dist_d;
  logic        held_valid_q, held_valid_d;
  logic [9:0]  points_q, points_d;

  logic        out_valid_q;
  logic [17:0] dist_q, dist_d;
  logic [9:0]  num_q, num_d;
  logic        last_q, last_d;
  fault_e      fault_q, fault_d;
  logic        res_d;

  logic        in_fire;
  logic [5:0]  digit_val;
  logic [7:0]  biased;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign biased     = dly_char_q - DigitBias;
  assign digit_val  = biased[5:0];

  always_comb begin
    phase_d      = phase_q;
    dly_char_d   = dly_char_q;
    dly_valid_d  = dly_valid_q;
    digit_sum_d  = digit_sum_q;
    digit_cnt_d  = digit_cnt_q;
    lf_run_d     = lf_run_q;
    held_dist_d  = held_dist_q;
    held_valid_d = held_valid_q;
    points_d     = points_q;
    res_d        = 1'b0;
    dist_d       = '0;
    num_d        = '0;
    last_d       = 1'b0;
    fault_d      = FAULT_OK;
    case (phase_q)
      PH_HDR_B: begin
        if (dly_char_q == CharM && rx_byte_i == CharD) begin
          phase_d = PH_ECHO;
        end else begin
          phase_d = PH_HDR_A;
          res_d   = 1'b1;
          fault_d = FAULT_HEADER;
        end
      end
      PH_ECHO: begin
        if (rx_byte_i == LfChar) phase_d = PH_ST0;
      end
      PH_ST0: begin
        dly_valid_d = (rx_byte_i == CharNine);
        phase_d     = PH_ST1;
      end
      PH_ST1: begin
        dly_valid_d = dly_valid_q && (rx_byte_i == CharNine);
        phase_d     = PH_ST2;
      end
      PH_ST2: begin
        dly_valid_d = dly_valid_q && (rx_byte_i == CharB);
        phase_d     = PH_ST3;
      end
      PH_ST3: begin
        if (dly_valid_q) begin
          dly_valid_d = 1'b0;
          phase_d     = PH_STAMP;
        end else begin
          phase_d = PH_HDR_A;
          res_d   = 1'b1;
          fault_d = FAULT_STATUS;
        end
      end
      PH_STAMP: begin
        if (rx_byte_i == LfChar) begin
          phase_d      = PH_DATA;
          dly_valid_d  = 1'b0;
          digit_sum_d  = '0;
          digit_cnt_d  = '0;
          lf_run_d     = 1'b0;
          held_valid_d = 1'b0;
          points_d     = '0;
        end
      end
      PH_DATA: begin
        if (rx_byte_i == LfChar) begin
          // the held character was the sum character: drop it
          dly_valid_d = 1'b0;
          if (!lf_run_q) begin
            lf_run_d = 1'b1;
          end else begin
            lf_run_d     = 1'b0;
            phase_d      = PH_HDR_A;
            digit_sum_d  = '0;
            digit_cnt_d  = '0;
            held_valid_d = 1'b0;
            if (held_valid_q) begin
              res_d  = 1'b1;
              dist_d = held_dist_q;
              num_d  = points_q;
              last_d = 1'b1;
            end
          end
        end else begin
          lf_run_d = 1'b0;
          if (dly_valid_q) begin
            if (digit_cnt_q != 2'd2) begin
              digit_sum_d = {digit_sum_q[5:0], digit_val};
              digit_cnt_d = digit_cnt_q + 2'd1;
            end else begin
              digit_sum_d  = '0;
              digit_cnt_d  = '0;
              held_dist_d  = {digit_sum_q, digit_val};
              held_valid_d = 1'b1;
              if (held_valid_q) begin
                res_d  = 1'b1;
                dist_d = held_dist_q;
                num_d  = points_q;
                if (points_q < IdxLimit) points_d = points_q + 10'd1;
              end
            end
          end
          dly_char_d  = rx_byte_i;
          dly_valid_d = 1'b1;
        end
      end
      default: begin
        dly_char_d = rx_byte_i;
        phase_d    = PH_HDR_B;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR_A;
      dly_char_q   <= '0;
      dly_valid_q  <= 1'b0;
      digit_sum_q  <= '0;
      digit_cnt_q  <= '0;
      lf_run_q     <= 1'b0;
      held_dist_q  <= '0;
      held_valid_q <= 1'b0;
      points_q     <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      dly_char_q   <= dly_char_d;
      dly_valid_q  <= dly_valid_d;
      digit_sum_q  <= digit_sum_d;
      digit_cnt_q  <= digit_cnt_d;
      lf_run_q     <= lf_run_d;
      held_dist_q  <= held_dist_d;
      held_valid_q <= held_valid_d;
      points_q     <= points_d;
    end
  end

  // Output register: load on a producing transfer, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && res_d) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_d) begin
      dist_q  <= dist_d;
      num_q   <= num_d;
      last_q  <= last_d;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign distance_o     = dist_q;
  assign point_number_o = num_q;
  assign scan_last_o    = last_q;
  assign fault_o        = fault_q;

  `SRD_ASSERT(a_fault_clean, !out_valid_q || fault_q == FAULT_OK || (dist_q == '0 && num_q == '0 && !last_q), "fault result carries data")
  `SRD_ASSERT(a_held_in_data, !held_valid_q || phase_q == PH_DATA, "held distance outside data lines")
  `SRD_ASSERT(a_points_cap, points_q <= IdxLimit, "point index beyond limit")
  `SRD_ASSERT_NEXT(a_last_clears, in_fire && res_d && last_d, !held_valid_q && phase_q == PH_HDR_A, "scan end did not return to header search")

endmodule
